// File: rtl/core/mops_pkg.sv
// Package of the move ordering table: sizes, opcodes, score constants,
// command and entry types, and the piece value tables.
// Used by every module of the block but mops_ram; it depends on nothing.
`default_nettype none

package mops_pkg;

  // Table size and derived widths.
  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int START_W     = 8;
  localparam int CMP_W       = (CNT_W > START_W) ? CNT_W : START_W;

  // Field widths of the stream payloads.
  localparam int MOVE_W     = 16;
  localparam int PIECE_W    = 3;
  localparam int HIST_W     = 16;
  localparam int SCORE_W    = 21;
  localparam int OPC_W      = 2;
  localparam int S_TDATA_W  = 56;
  localparam int M_TDATA_W  = 40;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Command queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Ordering scores.
  localparam int SCORE_HASH        = 1000000;
  localparam int SCORE_CAPTURE     = 500000;
  localparam int SCORE_PROMO       = 400000;
  localparam int SCORE_PROMO_QUEEN = 1000;
  localparam int SCORE_KILLER1     = 200000;
  localparam int SCORE_KILLER2     = 190000;
  localparam int VICTIM_SCALE      = 10;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_HASH_MOVE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KILLER_FIRST    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KILLER_SECOND   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KILLERS_PRESENT = 2'd3;

  // Piece type codes that need a name.
  localparam logic [PIECE_W-1:0] PIECE_NONE    = 3'd0;
  localparam logic [PIECE_W-1:0] PIECE_PAWN    = 3'd1;
  localparam logic [PIECE_W-1:0] PIECE_INVALID = 3'd7;

  typedef enum logic [OPC_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_PICK   = 2'd2
  } op_t;

  typedef logic signed [SCORE_W-1:0] score_t;

  // One stored table entry.
  typedef struct packed {
    score_t              score;
    logic [MOVE_W-1:0]   move;
  } entry_t;

  // One classified command from the front.
  typedef struct packed {
    op_t                 op;
    logic [MOVE_W-1:0]   move;
    score_t              score;
    logic [START_W-1:0]  start;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SWAP_A,
    ST_SWAP_B
  } back_state_t;

  // Victim value for the capture score.
  function automatic logic [13:0] victim_value(input logic [PIECE_W-1:0] piece);
    logic [13:0] v;
    unique case (piece)
      3'd1:    v = 14'd100;
      3'd2:    v = 14'd300;
      3'd3:    v = 14'd310;
      3'd4:    v = 14'd500;
      3'd5:    v = 14'd900;
      3'd6:    v = 14'd10000;
      default: v = 14'd0;
    endcase
    return v;
  endfunction

  // Attacker value: cheaper attackers rank higher.
  function automatic logic [2:0] attacker_value(input logic [PIECE_W-1:0] piece);
    logic [2:0] v;
    unique case (piece)
      3'd1:    v = 3'd5;
      3'd2:    v = 3'd4;
      3'd3:    v = 3'd3;
      3'd4:    v = 3'd2;
      3'd5:    v = 3'd1;
      default: v = 3'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/move_order_score_and_pick_unit.sv
// Top level of the move ordering table: front, command queue and back.
// Depends on mops_pkg, mops_front, mops_queue, mops_back and mops_ram.
//
// Usage: items arrive on the s_ stream, the opcode in s_tuser. A clear or an
// append gives no result; a pick gives one result item on the m_ stream with
// the picked move and score in m_tdata and the valid flag in m_tuser.
// Registers hash_move, killer_first, killer_second and killers_present are
// written through cfg_we/cfg_index/cfg_wdata; the user must write them only
// while the block is idle, which the block itself does not enforce. The front
// scores an item in the cycle it is accepted and places it in a four-deep
// command queue, so s_tready stays high until the queue fills. A pick from
// start index s over n = count - s entries reads the entry memory once per
// cycle (scan, then two swap writes on the single write port). The result
// sits in an output register; while the receiver stalls, the back holds
// before its next result and the queue keeps accepting items until it fills.
// Reset clears the count, the queue, the output valid flag and the
// configuration registers; the entry memory needs no clearing.
`default_nettype none

module move_order_score_and_pick_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // s_tdata from bit 0: move_code[15:0], captured_type[18:16],
  // mover_type[21:19], en_passant_flag[22], promotion_flag[23],
  // promotes_to_queen[24], history_value[40:25], start_index[48:41], zeros.
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [mops_pkg::S_TDATA_W-1:0]   s_tdata,
  // s_tuser: opcode[1:0].
  input  wire logic [mops_pkg::OPC_W-1:0]       s_tuser,
  // m_tdata from bit 0: picked_move[15:0], picked_score[36:16], zeros.
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [mops_pkg::M_TDATA_W-1:0]        m_tdata,
  // m_tuser: pick_valid[0].
  output logic [0:0]                            m_tuser,
  input  wire logic                             cfg_we,
  input  wire logic [mops_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mops_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  logic           q_full;
  logic           q_push;
  mops_pkg::cmd_t q_cmd;
  logic           q_pop;
  logic           q_valid;
  mops_pkg::cmd_t q_head;

  mops_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  mops_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (q_head)
  );

  mops_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_cmd    (q_head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

// File: rtl/core/mops_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
`default_nettype none

module mops_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/core/mops_front.sv
// Front of the move ordering table: holds the configuration registers,
// unpacks input items and scores appended moves into commands for the queue.
// Depends on mops_pkg.
`default_nettype none

module mops_front (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [mops_pkg::S_TDATA_W-1:0]      s_tdata,
  input  wire logic [mops_pkg::OPC_W-1:0]          s_tuser,
  input  wire logic                                cfg_we,
  input  wire logic [mops_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [mops_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  wire logic                                q_full,
  output logic                                     q_push,
  output mops_pkg::cmd_t                           q_cmd
);

  logic [mops_pkg::MOVE_W-1:0] hash_move;
  logic [mops_pkg::MOVE_W-1:0] killer_first;
  logic [mops_pkg::MOVE_W-1:0] killer_second;
  logic                        killers_present;

  logic [mops_pkg::MOVE_W-1:0]  move_code;
  logic [mops_pkg::PIECE_W-1:0] captured_type;
  logic [mops_pkg::PIECE_W-1:0] mover_type;
  logic                         en_passant_flag;
  logic                         promotion_flag;
  logic                         promotes_to_queen;
  logic [mops_pkg::HIST_W-1:0]  history_value;
  logic [mops_pkg::START_W-1:0] start_index;

  logic [mops_pkg::PIECE_W-1:0] victim;
  logic [mops_pkg::PIECE_W-1:0] mover;
  mops_pkg::score_t             score;
  logic                         op_known;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_move       <= '0;
      killer_first    <= '0;
      killer_second   <= '0;
      killers_present <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mops_pkg::CFG_HASH_MOVE:       hash_move       <= cfg_wdata;
        mops_pkg::CFG_KILLER_FIRST:    killer_first    <= cfg_wdata;
        mops_pkg::CFG_KILLER_SECOND:   killer_second   <= cfg_wdata;
        mops_pkg::CFG_KILLERS_PRESENT: killers_present <= cfg_wdata[0];
        default:                       hash_move       <= hash_move;
      endcase
    end
  end

  // Unpack the item fields from tdata.
  assign move_code         = s_tdata[15:0];
  assign captured_type     = s_tdata[18:16];
  assign mover_type        = s_tdata[21:19];
  assign en_passant_flag   = s_tdata[22];
  assign promotion_flag    = s_tdata[23];
  assign promotes_to_queen = s_tdata[24];
  assign history_value     = s_tdata[40:25];
  assign start_index       = s_tdata[48:41];

  // Piece type seven counts as no piece; an en-passant victim is a pawn.
  always_comb begin
    victim = (captured_type == mops_pkg::PIECE_INVALID) ? mops_pkg::PIECE_NONE
                                                          : captured_type;
    mover  = (mover_type == mops_pkg::PIECE_INVALID) ? mops_pkg::PIECE_NONE
                                                       : mover_type;
    if (en_passant_flag) begin
      victim = mops_pkg::PIECE_PAWN;
    end
  end

  // Score by fixed priority.
  always_comb begin
    priority if (move_code == hash_move) begin
      score = mops_pkg::score_t'(mops_pkg::SCORE_HASH);
    end else if (victim != mops_pkg::PIECE_NONE) begin
      score = mops_pkg::score_t'(mops_pkg::SCORE_CAPTURE)
            + mops_pkg::score_t'(mops_pkg::victim_value(victim))
              * mops_pkg::score_t'(mops_pkg::VICTIM_SCALE)
            + mops_pkg::score_t'(mops_pkg::attacker_value(mover));
    end else if (promotion_flag) begin
      score = mops_pkg::score_t'(mops_pkg::SCORE_PROMO)
            + (promotes_to_queen ? mops_pkg::score_t'(mops_pkg::SCORE_PROMO_QUEEN)
                                 : mops_pkg::score_t'(0));
    end else if (killers_present && (move_code == killer_first)) begin
      score = mops_pkg::score_t'(mops_pkg::SCORE_KILLER1);
    end else if (killers_present && (move_code == killer_second)) begin
      score = mops_pkg::score_t'(mops_pkg::SCORE_KILLER2);
    end else begin
      score = mops_pkg::score_t'(signed'(history_value));
    end
  end

  // Only known opcodes become commands; the unused code is taken and dropped.
  always_comb begin
    unique case (s_tuser)
      mops_pkg::OP_CLEAR,
      mops_pkg::OP_APPEND,
      mops_pkg::OP_PICK: op_known = 1'b1;
      default:           op_known = 1'b0;
    endcase
  end

  assign s_tready    = !q_full;
  assign q_push      = s_tvalid && !q_full && op_known;
  assign q_cmd.op    = mops_pkg::op_t'(s_tuser);
  assign q_cmd.move  = move_code;
  assign q_cmd.score = score;
  assign q_cmd.start = start_index;

endmodule

`default_nettype wire

// File: rtl/core/mops_queue.sv
// Short command queue between the front and the back of the move table.
// Depends on mops_pkg.
`default_nettype none

module mops_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire mops_pkg::cmd_t push_cmd,
  output logic                full,
  input  wire logic           pop,
  output logic                head_valid,
  output mops_pkg::cmd_t      head_cmd
);

  mops_pkg::cmd_t                slots [mops_pkg::QUEUE_DEPTH];
  logic [mops_pkg::QPTR_W-1:0]   wr_ptr;
  logic [mops_pkg::QPTR_W-1:0]   rd_ptr;
  logic [mops_pkg::QCNT_W-1:0]   fill;
  logic                          do_push;
  logic                          do_pop;

  assign full       = (fill == mops_pkg::QCNT_W'(mops_pkg::QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head_cmd   = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + mops_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + mops_pkg::QPTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   fill <= fill + mops_pkg::QCNT_W'(1);
        2'b01:   fill <= fill - mops_pkg::QCNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

  // Command storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/mops_back.sv
// Back of the move ordering table: entry memory, entry count, pick scan,
// swap and the output register.
// Depends on mops_pkg and mops_ram.
`default_nettype none

module mops_back (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            q_valid,
  input  wire mops_pkg::cmd_t                  q_cmd,
  output logic                                 q_pop,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [mops_pkg::M_TDATA_W-1:0]       m_tdata,
  output logic [0:0]                           m_tuser
);

  localparam int IDX_W = mops_pkg::IDX_W;
  localparam int CNT_W = mops_pkg::CNT_W;
  localparam int CMP_W = mops_pkg::CMP_W;

  mops_pkg::back_state_t state, state_next;
  logic [CNT_W-1:0]      count, count_next;
  logic [CNT_W-1:0]      ptr, ptr_next;
  logic [IDX_W-1:0]      data_idx, data_idx_next;
  logic [IDX_W-1:0]      start_idx, start_idx_next;
  logic [IDX_W-1:0]      top_idx, top_idx_next;
  mops_pkg::entry_t      best, best_next;
  mops_pkg::entry_t      start_ent, start_ent_next;
  logic                  out_vld, out_vld_next;
  mops_pkg::entry_t      out_ent, out_ent_next;
  logic                  out_ok, out_ok_next;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  mops_pkg::entry_t      ram_wdata;
  logic [IDX_W-1:0]      ram_raddr;
  mops_pkg::entry_t      ram_rdata;
  logic                  out_free;

  mops_ram #(
    .WIDTH ($bits(mops_pkg::entry_t)),
    .DEPTH (mops_pkg::TABLE_DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free = !out_vld || m_tready;

  // State and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= mops_pkg::ST_IDLE;
      count   <= '0;
      out_vld <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      out_vld <= out_vld_next;
    end
  end

  // Scan and output payload registers.
  always_ff @(posedge clk) begin
    ptr       <= ptr_next;
    data_idx  <= data_idx_next;
    start_idx <= start_idx_next;
    top_idx   <= top_idx_next;
    best      <= best_next;
    start_ent <= start_ent_next;
    out_ent   <= out_ent_next;
    out_ok    <= out_ok_next;
  end

  // Command sequencer.
  always_comb begin
    state_next     = state;
    count_next     = count;
    ptr_next       = ptr;
    data_idx_next  = data_idx;
    start_idx_next = start_idx;
    top_idx_next   = top_idx;
    best_next      = best;
    start_ent_next = start_ent;
    out_vld_next   = out_vld && !m_tready;
    out_ent_next   = out_ent;
    out_ok_next    = out_ok;
    q_pop          = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = top_idx;
    ram_wdata      = start_ent;
    ram_raddr      = ptr[IDX_W-1:0];

    unique case (state)
      mops_pkg::ST_IDLE: begin
        if (q_valid) begin
          unique case (q_cmd.op)
            mops_pkg::OP_CLEAR: begin
              count_next = '0;
              q_pop      = 1'b1;
            end
            mops_pkg::OP_APPEND: begin
              // A full table drops the append.
              if (count != CNT_W'(mops_pkg::TABLE_DEPTH)) begin
                ram_we          = 1'b1;
                ram_waddr       = count[IDX_W-1:0];
                ram_wdata.move  = q_cmd.move;
                ram_wdata.score = q_cmd.score;
                count_next      = count + CNT_W'(1);
              end
              q_pop = 1'b1;
            end
            mops_pkg::OP_PICK: begin
              if (CMP_W'(q_cmd.start) >= CMP_W'(count)) begin
                // Start past the count: empty result, table unchanged.
                if (out_free) begin
                  out_vld_next = 1'b1;
                  out_ent_next = '0;
                  out_ok_next  = 1'b0;
                  q_pop        = 1'b1;
                end
              end else begin
                ram_raddr      = IDX_W'(q_cmd.start);
                data_idx_next  = IDX_W'(q_cmd.start);
                start_idx_next = IDX_W'(q_cmd.start);
                ptr_next       = CNT_W'(q_cmd.start) + CNT_W'(1);
                q_pop          = 1'b1;
                state_next     = mops_pkg::ST_SCAN;
              end
            end
            default: q_pop = 1'b1;
          endcase
        end
      end

      mops_pkg::ST_SCAN: begin
        // Compare the entry read last cycle; ties keep the lower index.
        if (data_idx == start_idx) begin
          best_next      = ram_rdata;
          top_idx_next   = data_idx;
          start_ent_next = ram_rdata;
        end else if (ram_rdata.score > best.score) begin
          best_next    = ram_rdata;
          top_idx_next = data_idx;
        end
        if (ptr < count) begin
          ram_raddr     = ptr[IDX_W-1:0];
          data_idx_next = ptr[IDX_W-1:0];
          ptr_next      = ptr + CNT_W'(1);
        end else begin
          state_next = mops_pkg::ST_SWAP_A;
        end
      end

      mops_pkg::ST_SWAP_A: begin
        // Start entry moves to where the best one was.
        ram_we     = 1'b1;
        ram_waddr  = top_idx;
        ram_wdata  = start_ent;
        state_next = mops_pkg::ST_SWAP_B;
      end

      mops_pkg::ST_SWAP_B: begin
        // Best entry goes into the start slot and out as the result.
        if (out_free) begin
          ram_we       = 1'b1;
          ram_waddr    = start_idx;
          ram_wdata    = best;
          out_vld_next = 1'b1;
          out_ent_next = best;
          out_ok_next  = 1'b1;
          state_next   = mops_pkg::ST_IDLE;
        end
      end

      default: state_next = mops_pkg::ST_IDLE;
    endcase
  end

  assign m_tvalid = out_vld;
  assign m_tdata  = {3'b000, out_ent.score, out_ent.move};
  assign m_tuser  = out_ok;

  // The count never passes the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(mops_pkg::TABLE_DEPTH))
    else $error("entry count above table depth");

  // The scan pointer stays within the filled part of the table.
  a_scan_ptr: assert property (@(posedge clk) disable iff (rst)
    (state == mops_pkg::ST_SCAN) |-> (ptr <= count))
    else $error("scan pointer past entry count");

  // The best entry lies between the start slot and the count.
  a_best_range: assert property (@(posedge clk) disable iff (rst)
    (state == mops_pkg::ST_SWAP_A) |->
      ((CNT_W'(top_idx) >= CNT_W'(start_idx)) && (CNT_W'(top_idx) < count)))
    else $error("best index outside the scanned range");

  // The count changes only between commands.
  a_count_held: assert property (@(posedge clk) disable iff (rst)
    (state != mops_pkg::ST_IDLE) |=> $stable(count))
    else $error("entry count changed during a pick");

endmodule

`default_nettype wire

// File: tb/tb_move_order_score_and_pick_unit.sv
// Self-checking bench for the move ordering table: scores appended moves,
// then checks each picked move, score and valid flag against its own table.
// Depends on mops_pkg and the move_order_score_and_pick_unit RTL.
`default_nettype none

module tb_move_order_score_and_pick_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // Opcode value that the block ignores.
  localparam logic [mops_pkg::OPC_W-1:0] OPC_UNUSED = 2'd3;
  // Cycles for the back to finish queued clears and appends, or one full pick.
  localparam int DRAIN_CYCLES = 300;
  // Cycles with no accepted item before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 1600;

  // One input item, field by field.
  typedef struct {
    logic [mops_pkg::OPC_W-1:0]          opc;
    logic [mops_pkg::MOVE_W-1:0]         mv;
    logic [mops_pkg::PIECE_W-1:0]        victim;
    logic [mops_pkg::PIECE_W-1:0]        attacker;
    logic                                ep;
    logic                                promo;
    logic                                queen;
    logic signed [mops_pkg::HIST_W-1:0]  hist;
    logic [mops_pkg::START_W-1:0]        first_slot;
  } move_cmd_t;

  // One pick result.
  typedef struct {
    logic [mops_pkg::MOVE_W-1:0] mv;
    mops_pkg::score_t            score;
    logic                        ok;
  } pick_out_t;

  logic clk;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [mops_pkg::S_TDATA_W-1:0] s_tdata = '0;
  logic [mops_pkg::OPC_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [mops_pkg::M_TDATA_W-1:0] m_tdata;
  logic [0:0] m_tuser;
  logic cfg_we = 1'b0;
  logic [mops_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mops_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  move_order_score_and_pick_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the move table and the configuration registers.
  logic [mops_pkg::MOVE_W-1:0] tbl_move [mops_pkg::TABLE_DEPTH];
  int                          tbl_score [mops_pkg::TABLE_DEPTH];
  int                          fill_count = 0;
  logic [mops_pkg::MOVE_W-1:0] hash_cfg = '0;
  logic [mops_pkg::MOVE_W-1:0] killer1_cfg = '0;
  logic [mops_pkg::MOVE_W-1:0] killer2_cfg = '0;
  logic                        killers_on = 1'b0;

  move_cmd_t cmd_backlog [$];
  pick_out_t picks_due [$];
  move_cmd_t cur_cmd;
  int sent_total = 0;
  int accepted_total = 0;
  int items_issued = 0;
  int mismatches = 0;
  int send_wait = 0;
  int recv_wait = 0;
  int quiet_cycles = 0;
  bit send_burst = 1'b0;
  bit recv_burst = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Victim value for the capture score; type seven counts as no piece.
  function automatic int victim_points(input logic [mops_pkg::PIECE_W-1:0] p);
    case (p)
      3'd1: return 100;
      3'd2: return 300;
      3'd3: return 310;
      3'd4: return 500;
      3'd5: return 900;
      3'd6: return 10000;
      default: return 0;
    endcase
  endfunction

  // Attacker value: the cheaper the attacker, the higher the bonus.
  function automatic int attacker_points(input logic [mops_pkg::PIECE_W-1:0] p);
    case (p)
      3'd1: return 5;
      3'd2: return 4;
      3'd3: return 3;
      3'd4: return 2;
      3'd5: return 1;
      default: return 0;
    endcase
  endfunction

  // Ordering score of an appended move, by fixed priority.
  function automatic int score_move(input move_cmd_t c);
    logic [mops_pkg::PIECE_W-1:0] vic;
    vic = (c.victim == mops_pkg::PIECE_INVALID) ? mops_pkg::PIECE_NONE : c.victim;
    if (c.mv == hash_cfg) return mops_pkg::SCORE_HASH;
    if (vic != mops_pkg::PIECE_NONE || c.ep) begin
      if (c.ep) vic = mops_pkg::PIECE_PAWN;
      return mops_pkg::SCORE_CAPTURE + victim_points(vic) * mops_pkg::VICTIM_SCALE
             + attacker_points(c.attacker);
    end
    if (c.promo)
      return mops_pkg::SCORE_PROMO + (c.queen ? mops_pkg::SCORE_PROMO_QUEEN : 0);
    if (killers_on && c.mv == killer1_cfg) return mops_pkg::SCORE_KILLER1;
    if (killers_on && c.mv == killer2_cfg) return mops_pkg::SCORE_KILLER2;
    return int'(c.hist);
  endfunction

  // Apply one accepted item to the shadow table; a pick queues its result.
  task automatic table_update(input move_cmd_t c);
    int best;
    int slot;
    logic [mops_pkg::MOVE_W-1:0] mv_tmp;
    int sc_tmp;
    pick_out_t res;
    case (c.opc)
      mops_pkg::OP_CLEAR: fill_count = 0;
      mops_pkg::OP_APPEND: begin
        if (fill_count < mops_pkg::TABLE_DEPTH) begin
          tbl_move[fill_count] = c.mv;
          tbl_score[fill_count] = score_move(c);
          fill_count++;
        end
      end
      mops_pkg::OP_PICK: begin
        slot = int'(c.first_slot);
        if (slot >= fill_count) begin
          res.mv = '0;
          res.score = '0;
          res.ok = 1'b0;
        end else begin
          // Strictly greater keeps the lowest index on ties.
          best = slot;
          for (int i = slot + 1; i < fill_count; i++) begin
            if (tbl_score[i] > tbl_score[best]) best = i;
          end
          mv_tmp = tbl_move[best];
          sc_tmp = tbl_score[best];
          tbl_move[best] = tbl_move[slot];
          tbl_score[best] = tbl_score[slot];
          tbl_move[slot] = mv_tmp;
          tbl_score[slot] = sc_tmp;
          res.mv = mv_tmp;
          res.score = mops_pkg::score_t'(sc_tmp);
          res.ok = 1'b1;
        end
        picks_due.push_back(res);
      end
      default: ;
    endcase
  endtask

  function automatic logic [mops_pkg::S_TDATA_W-1:0] pack_cmd(input move_cmd_t c);
    logic [mops_pkg::S_TDATA_W-1:0] d;
    d = '0;
    d[15:0] = c.mv;
    d[18:16] = c.victim;
    d[21:19] = c.attacker;
    d[22] = c.ep;
    d[23] = c.promo;
    d[24] = c.queen;
    d[40:25] = c.hist;
    d[48:41] = c.first_slot;
    return d;
  endfunction

  // Item with every field random; the opcode is given.
  function automatic move_cmd_t rand_cmd(input logic [mops_pkg::OPC_W-1:0] opc);
    move_cmd_t c;
    c.opc = opc;
    c.mv = 16'($urandom);
    c.victim = 3'($urandom_range(0, 7));
    c.attacker = 3'($urandom_range(0, 7));
    c.ep = 1'($urandom_range(0, 1));
    c.promo = 1'($urandom_range(0, 1));
    c.queen = 1'($urandom_range(0, 1));
    c.hist = 16'($urandom);
    c.first_slot = 8'($urandom);
    return c;
  endfunction

  function automatic move_cmd_t mk_append(input logic [mops_pkg::MOVE_W-1:0] mv,
                                          input logic [mops_pkg::PIECE_W-1:0] victim,
                                          input logic [mops_pkg::PIECE_W-1:0] attacker,
                                          input logic ep, input logic promo,
                                          input logic queen,
                                          input logic [mops_pkg::HIST_W-1:0] hist);
    move_cmd_t c;
    c = rand_cmd(mops_pkg::OP_APPEND);
    c.mv = mv;
    c.victim = victim;
    c.attacker = attacker;
    c.ep = ep;
    c.promo = promo;
    c.queen = queen;
    c.hist = hist;
    return c;
  endfunction

  function automatic move_cmd_t mk_pick(input int slot);
    move_cmd_t c;
    c = rand_cmd(mops_pkg::OP_PICK);
    c.first_slot = 8'(slot);
    return c;
  endfunction

  // Append with a realistic mix: quiet moves, captures, promotions, and
  // move codes that hit the hash and killer registers.
  function automatic move_cmd_t rand_append();
    move_cmd_t c;
    c = rand_cmd(mops_pkg::OP_APPEND);
    case ($urandom_range(0, 15))
      0, 1, 2: c.mv = hash_cfg;
      3, 4:    c.mv = killer1_cfg;
      5, 6:    c.mv = killer2_cfg;
      default: ;
    endcase
    case ($urandom_range(0, 3))
      0, 1:    c.victim = mops_pkg::PIECE_NONE;
      2:       c.victim = mops_pkg::PIECE_INVALID;
      default: ;
    endcase
    c.ep = ($urandom_range(0, 7) == 0);
    c.promo = ($urandom_range(0, 5) == 0);
    // Extremes and a few small values so that ties are common.
    case ($urandom_range(0, 7))
      0: c.hist = 16'sh8000;
      1: c.hist = 16'sh7FFF;
      2: c.hist = 16'shFFFF;
      3: c.hist = 16'sh0000;
      4: c.hist = 16'sh0001;
      default: ;
    endcase
    return c;
  endfunction

  function automatic logic [mops_pkg::MOVE_W-1:0] draw_code();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int draw_gap(input bit burst);
    return burst ? 0 : $urandom_range(0, 15);
  endfunction

  task automatic push_cmd(input move_cmd_t c);
    cmd_backlog.push_back(c);
    sent_total++;
    if (c.opc != OPC_UNUSED) items_issued++;
  endtask

  // Wait until every item is taken and every pick answered, then let the
  // back finish any clear or append still in its queue.
  task automatic wait_idle();
    while (accepted_total != sent_total || picks_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [mops_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mops_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      mops_pkg::CFG_HASH_MOVE:       hash_cfg = val;
      mops_pkg::CFG_KILLER_FIRST:    killer1_cfg = val;
      mops_pkg::CFG_KILLER_SECOND:   killer2_cfg = val;
      mops_pkg::CFG_KILLERS_PRESENT: killers_on = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [mops_pkg::MOVE_W-1:0] hv,
                            input logic [mops_pkg::MOVE_W-1:0] k1,
                            input logic [mops_pkg::MOVE_W-1:0] k2, input logic on);
    write_reg(mops_pkg::CFG_HASH_MOVE, hv);
    write_reg(mops_pkg::CFG_KILLER_FIRST, k1);
    write_reg(mops_pkg::CFG_KILLER_SECOND, k2);
    write_reg(mops_pkg::CFG_KILLERS_PRESENT, {15'd0, on});
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Driver: presents items from the backlog, with a random gap per item.
  always @(posedge clk) begin : drive_items
    bit take_next;
    int gap;
    take_next = 1'b0;
    if (rst) begin
      s_tvalid <= 1'b0;
      send_wait <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        table_update(cur_cmd);
        accepted_total++;
        if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
        gap = draw_gap(send_burst);
        if (gap == 0 && cmd_backlog.size() != 0) begin
          take_next = 1'b1;
        end else begin
          s_tvalid <= 1'b0;
          send_wait <= gap;
        end
      end else if (!s_tvalid) begin
        if (send_wait != 0) send_wait <= send_wait - 1;
        else if (cmd_backlog.size() != 0) take_next = 1'b1;
      end
      if (take_next) begin
        cur_cmd = cmd_backlog.pop_front();
        s_tdata <= pack_cmd(cur_cmd);
        s_tuser <= cur_cmd.opc;
        s_tvalid <= 1'b1;
      end
    end
  end

  // Monitor: takes pick results with random stalls and checks each one
  // against the oldest pick still owed.
  always @(posedge clk) begin : check_picks
    pick_out_t want;
    logic [mops_pkg::MOVE_W-1:0] got_mv;
    mops_pkg::score_t got_sc;
    logic got_ok;
    int gap;
    if (rst) begin
      m_tready <= 1'b0;
      recv_wait <= 0;
    end else if (m_tvalid && m_tready) begin
      got_mv = m_tdata[15:0];
      got_sc = m_tdata[36:16];
      got_ok = m_tuser[0];
      if (picks_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected pick result: move %h score %0d valid %b",
                   got_mv, got_sc, got_ok);
      end else begin
        want = picks_due.pop_front();
        if (got_mv !== want.mv || got_sc !== want.score || got_ok !== want.ok) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"pick mismatch: want move %h score %0d valid %b, ",
                      "got move %h score %0d valid %b"},
                     want.mv, want.score, want.ok, got_mv, got_sc, got_ok);
        end
      end
      if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
      gap = draw_gap(recv_burst);
      if (gap != 0) begin
        m_tready <= 1'b0;
        recv_wait <= gap;
      end
    end else if (!m_tready) begin
      if (recv_wait != 0) recv_wait <= recv_wait - 1;
      else m_tready <= 1'b1;
    end
  end

  // Watchdog on cycles in which neither side moves an item.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb_move_order_score_and_pick_unit: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    move_cmd_t c;
    logic [mops_pkg::MOVE_W-1:0] hv;
    logic [mops_pkg::MOVE_W-1:0] k1;
    logic [mops_pkg::MOVE_W-1:0] k2;
    int phase_no;
    int n_app;
    int n_pick;
    int est_count;
    bit big;
    phase_no = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part: every scoring rule, ties, ignored opcode, edge picks.
    set_config(16'h1234, 16'h00AA, 16'h00BB, 1'b1);
    push_cmd(mk_pick(0));                    // pick from an empty table
    push_cmd(rand_cmd(mops_pkg::OP_CLEAR));
    push_cmd(mk_append(16'h1234, 3'd5, 3'd1, 1'b0, 1'b1, 1'b1, 16'h0000)); // hash wins
    push_cmd(mk_append(16'h0001, 3'd6, 3'd1, 1'b0, 1'b0, 1'b0, 16'h0010)); // king by pawn
    push_cmd(mk_append(16'h0002, 3'd7, 3'd7, 1'b0, 1'b1, 1'b1, 16'h0020)); // type seven
    push_cmd(mk_append(16'h0003, 3'd0, 3'd1, 1'b1, 1'b0, 1'b0, 16'h0030)); // en passant
    push_cmd(mk_append(16'h0004, 3'd5, 3'd2, 1'b1, 1'b0, 1'b0, 16'h0040)); // ep over victim
    push_cmd(mk_append(16'h00AA, 3'd0, 3'd0, 1'b0, 1'b1, 1'b0, 16'h0050)); // promo > killer
    push_cmd(mk_append(16'h00AA, 3'd0, 3'd3, 1'b0, 1'b0, 1'b0, 16'h0060)); // first killer
    push_cmd(mk_append(16'h00BB, 3'd7, 3'd0, 1'b0, 1'b0, 1'b1, 16'h0070)); // second killer
    push_cmd(mk_append(16'hFFFF, 3'd0, 3'd0, 1'b0, 1'b0, 1'b0, 16'h8000)); // lowest history
    push_cmd(mk_append(16'h0000, 3'd0, 3'd0, 1'b0, 1'b0, 1'b0, 16'h7FFF)); // highest history
    push_cmd(mk_append(16'h0005, 3'd1, 3'd6, 1'b0, 1'b0, 1'b0, 16'h0080)); // pawn by king
    push_cmd(mk_append(16'h0006, 3'd2, 3'd7, 1'b0, 1'b0, 1'b0, 16'h0090)); // bad attacker
    push_cmd(mk_append(16'h00BB, 3'd0, 3'd4, 1'b0, 1'b0, 1'b0, 16'h00A0)); // tie on killer
    push_cmd(rand_cmd(OPC_UNUSED));
    for (int j = 0; j < 5; j++) push_cmd(mk_pick(j));
    push_cmd(mk_pick(13));                   // start equal to the count
    push_cmd(mk_pick(14));                   // start one past the count
    push_cmd(mk_pick(255));                  // start far past the count

    // Random phases: new settings, a fill, then a selection-sort run of picks
    // from slot zero upward, with some broken sequences and noise mixed in.
    while (items_issued < RANDOM_ITEMS) begin
      wait_idle();
      hv = draw_code();
      k1 = ($urandom_range(0, 7) == 0) ? hv : draw_code();
      k2 = ($urandom_range(0, 7) == 0) ? k1 : draw_code();
      set_config(hv, k1, k2, 1'($urandom_range(0, 1)));
      phase_no++;
      big = (phase_no % 16 == 7);
      est_count = fill_count;
      if (big || $urandom_range(0, 4) != 0) begin
        push_cmd(rand_cmd(mops_pkg::OP_CLEAR));
        est_count = 0;
      end
      n_app = big ? $urandom_range(250, 270) : $urandom_range(1, 24);
      for (int j = 0; j < n_app; j++) begin
        push_cmd(rand_append());
        if ($urandom_range(0, 19) == 0) push_cmd(rand_cmd(OPC_UNUSED));
      end
      est_count = (est_count + n_app > mops_pkg::TABLE_DEPTH) ? mops_pkg::TABLE_DEPTH
                                                              : est_count + n_app;
      n_pick = big ? $urandom_range(4, 24) : $urandom_range(0, est_count + 1);
      for (int j = 0; j < n_pick; j++) begin
        push_cmd(mk_pick(j));
        case ($urandom_range(0, 23))
          0: push_cmd(rand_append());
          1: push_cmd(rand_cmd(OPC_UNUSED));
          2: push_cmd(mk_pick($urandom_range(0, 255)));
          default: ;
        endcase
      end
      // Picks around the end of the table, and anywhere.
      repeat ($urandom_range(0, 3)) begin
        if ($urandom_range(0, 1) != 0)
          push_cmd(mk_pick(est_count - 1 + $urandom_range(0, 2)));
        else
          push_cmd(mk_pick($urandom_range(0, 255)));
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("tb_move_order_score_and_pick_unit: done, clean");
    end else begin
      $display("tb_move_order_score_and_pick_unit: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
